### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    // quotient bits produced by the divider chain, one per cell
    localparam int QBITS = 33;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic signed [31:0] lhs_real;
        logic signed [31:0] lhs_imag;
        logic signed [31:0] rhs_real;
        logic signed [31:0] rhs_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               overflow;
        logic               div_by_zero;
    } t_out_word;

    // one divide lane: partial remainder, dividend bits still to enter,
    // quotient bits so far, sign and early overflow
    typedef struct packed {
        logic [63:0]      rem;
        logic [QBITS-1:0] num;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             big;
    } t_div_lane;

    typedef struct packed {
        logic               is_div;
        logic               dz;
        logic signed [31:0] byp_real;
        logic signed [31:0] byp_imag;
        logic               byp_ovf;
        logic [63:0]        den;
        t_div_lane          re;
        t_div_lane          im;
    } t_cell_word;

endpackage

### rtl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for both result parts, registered.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  cau_pkg::t_cell_word i_word,
    output logic              o_valid,
    output cau_pkg::t_cell_word o_word
);
    import cau_pkg::*;

    function automatic t_div_lane div_step(input t_div_lane l, input logic [63:0] den);
        logic [64:0] t;
        logic        ge;
        t_div_lane   r;
        t  = {l.rem, l.num[QBITS-1]};
        ge = (t >= {1'b0, den});
        r  = l;
        r.rem = ge ? 64'(t - {1'b0, den}) : t[63:0];
        r.num = {l.num[QBITS-2:0], 1'b0};
        r.quo = {l.quo[QBITS-2:0], ge};
        return r;
    endfunction

    logic       r_vld;
    t_cell_word r_word;
    t_cell_word n_word;

    always_comb begin
        n_word    = i_word;
        n_word.re = div_step(i_word.re, i_word.den);
        n_word.im = div_step(i_word.im, i_word.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

### rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Add, subtract, multiply and divide of signed fixed-point complex words.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while o_stall is low, and every word gives
// one result word, in order, after a multiply stage, a sum stage, a setup
// stage, one divider cell per quotient bit (33), and the output register.
// The row of divider cells sets the latency; all actions go through it so
// that results stay in order. Products are floored by FRAC_BITS, quotients
// truncate toward zero, parts out of 32-bit range saturate and set overflow,
// a zero divisor gives zero parts and div_by_zero.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cau_pkg::t_in_word  i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output cau_pkg::t_out_word o_word
);
    import cau_pkg::*;

    localparam int NW = 64 + FRAC_BITS;

    function automatic logic [32:0] sat66(input logic signed [65:0] v);
        logic ovf;
        logic [31:0] val;
        ovf = 1'b0;
        val = v[31:0];
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            val = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            val = 32'h8000_0000;
        end
        return {ovf, val};
    endfunction

    function automatic t_div_lane lane_init(input logic signed [65:0] x,
                                            input logic [63:0] den);
        logic [65:0]   mag;
        logic [NW-1:0] n;
        logic [NW-1:0] top;
        t_div_lane     l;
        mag   = x[65] ? 66'(-x) : x;
        n     = {mag[63:0], {FRAC_BITS{1'b0}}};
        top   = n >> QBITS;
        l.big = (top >= NW'(den));
        l.rem = top[63:0];
        l.num = n[QBITS-1:0];
        l.quo = '0;
        l.neg = x[65];
        return l;
    endfunction

    function automatic logic [32:0] lane_done(input t_div_lane l);
        logic [QBITS-1:0] lim;
        logic             ovf;
        logic [31:0]      val;
        lim = l.neg ? QBITS'(33'h1_0000_0000 >> 1) : QBITS'(33'h0_7FFF_FFFF);
        ovf = l.big || (l.quo > lim);
        if (ovf) begin
            val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            val = l.neg ? 32'(-l.quo) : l.quo[31:0];
        end
        return {ovf, val};
    endfunction

    logic r_o_vld;
    logic adv;
    assign adv     = !r_o_vld || !i_stall;
    assign o_stall = !adv;

    // multiply stage
    logic               r_a_vld;
    t_action            r_a_act;
    logic signed [63:0] r_a_ac, r_a_bd, r_a_ad, r_a_bc, r_a_cc, r_a_dd;
    logic [32:0]        r_a_byp_re, r_a_byp_im;
    logic signed [32:0] s_re, s_im;

    always_comb begin
        if (i_word.action == ACT_SUB) begin
            s_re = 33'(i_word.lhs_real) - 33'(i_word.rhs_real);
            s_im = 33'(i_word.lhs_imag) - 33'(i_word.rhs_imag);
        end else begin
            s_re = 33'(i_word.lhs_real) + 33'(i_word.rhs_real);
            s_im = 33'(i_word.lhs_imag) + 33'(i_word.rhs_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_act    <= i_word.action;
            r_a_ac     <= i_word.lhs_real * i_word.rhs_real;
            r_a_bd     <= i_word.lhs_imag * i_word.rhs_imag;
            r_a_ad     <= i_word.lhs_real * i_word.rhs_imag;
            r_a_bc     <= i_word.lhs_imag * i_word.rhs_real;
            r_a_cc     <= i_word.rhs_real * i_word.rhs_real;
            r_a_dd     <= i_word.rhs_imag * i_word.rhs_imag;
            r_a_byp_re <= sat66(66'(s_re));
            r_a_byp_im <= sat66(66'(s_im));
        end
    end

    // sum stage
    logic               r_b_vld;
    t_action            r_b_act;
    logic signed [65:0] r_b_mre, r_b_mim, r_b_dre, r_b_dim;
    logic [63:0]        r_b_den;
    logic [32:0]        r_b_byp_re, r_b_byp_im;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_act    <= r_a_act;
            r_b_mre    <= 66'(r_a_ac) - 66'(r_a_bd);
            r_b_mim    <= 66'(r_a_ad) + 66'(r_a_bc);
            r_b_dre    <= 66'(r_a_ac) + 66'(r_a_bd);
            r_b_dim    <= 66'(r_a_bc) - 66'(r_a_ad);
            r_b_den    <= r_a_cc + r_a_dd;
            r_b_byp_re <= r_a_byp_re;
            r_b_byp_im <= r_a_byp_im;
        end
    end

    // divider setup stage
    logic        r_c_vld;
    t_cell_word  r_c_word;
    t_cell_word  n_c_word;
    logic [32:0] m_re, m_im;

    always_comb begin
        m_re = sat66(r_b_mre >>> FRAC_BITS);
        m_im = sat66(r_b_mim >>> FRAC_BITS);
        n_c_word.is_div = (r_b_act == ACT_DIV);
        n_c_word.dz     = (r_b_den == 64'd0);
        n_c_word.den    = r_b_den;
        n_c_word.re     = lane_init(r_b_dre, r_b_den);
        n_c_word.im     = lane_init(r_b_dim, r_b_den);
        if (r_b_act == ACT_MUL) begin
            n_c_word.byp_real = m_re[31:0];
            n_c_word.byp_imag = m_im[31:0];
            n_c_word.byp_ovf  = m_re[32] | m_im[32];
        end else begin
            n_c_word.byp_real = r_b_byp_re[31:0];
            n_c_word.byp_imag = r_b_byp_im[31:0];
            n_c_word.byp_ovf  = r_b_byp_re[32] | r_b_byp_im[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_word <= n_c_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // divider chain
    logic       c_vld  [0:QBITS];
    t_cell_word c_word [0:QBITS];

    assign c_vld[0]  = r_c_vld;
    assign c_word[0] = r_c_word;

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_vld[g]),
            .i_word  (c_word[g]),
            .o_valid (c_vld[g+1]),
            .o_word  (c_word[g+1])
        );
    end

    // output register
    t_out_word  r_o_word;
    t_out_word  n_o_word;
    t_cell_word w;
    logic [32:0] q_re, q_im;

    always_comb begin
        w    = c_word[QBITS];
        q_re = lane_done(w.re);
        q_im = lane_done(w.im);
        if (!w.is_div) begin
            n_o_word.res_real    = w.byp_real;
            n_o_word.res_imag    = w.byp_imag;
            n_o_word.overflow    = w.byp_ovf;
            n_o_word.div_by_zero = 1'b0;
        end else if (w.dz) begin
            n_o_word.res_real    = '0;
            n_o_word.res_imag    = '0;
            n_o_word.overflow    = 1'b0;
            n_o_word.div_by_zero = 1'b1;
        end else begin
            n_o_word.res_real    = q_re[31:0];
            n_o_word.res_imag    = q_im[31:0];
            n_o_word.overflow    = q_re[32] | q_im[32];
            n_o_word.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= c_vld[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_valid = r_o_vld;
    assign o_word  = r_o_word;

endmodule

### dv/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench: directed and random complex words with random idling,
// results predicted in 128-bit integer arithmetic and compared in order.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    bit        failed = 1'b0;
    int        cycle_count = 0;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [31:0] saturate(logic signed [127:0] v, ref bit ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // (x * 2^FRAC) / den truncated toward zero, magnitude clamped at 2^32
    function automatic logic signed [127:0] scaled_quotient(logic signed [127:0] x,
                                                           logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (x < 0) ? -x : x;
        q = (mag << FRAC) / den;
        if (q > (128'd1 << 32)) q = 128'd1 << 32;
        return (x < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_out_word complex_result(t_in_word w);
        t_out_word r;
        bit ovf;
        logic signed [127:0] a, b, c, d, re, im, den;
        ovf = 1'b0;
        r = '0;
        a = w.lhs_real; b = w.lhs_imag; c = w.rhs_real; d = w.rhs_imag;
        case (w.action)
            ACT_ADD: begin
                r.res_real = saturate(a + c, ovf);
                r.res_imag = saturate(b + d, ovf);
            end
            ACT_SUB: begin
                r.res_real = saturate(a - c, ovf);
                r.res_imag = saturate(b - d, ovf);
            end
            ACT_MUL: begin
                re = (a * c - b * d) >>> FRAC;
                im = (a * d + b * c) >>> FRAC;
                r.res_real = saturate(re, ovf);
                r.res_imag = saturate(im, ovf);
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    r.div_by_zero = 1'b1;
                end else begin
                    r.res_real = saturate(scaled_quotient(a * c + b * d, den), ovf);
                    r.res_imag = saturate(scaled_quotient(b * c - a * d, den), ovf);
                end
            end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] random_part();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'hffffffff;
            4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.action = t_action'($urandom_range(0, 3));
        w.lhs_real = random_part();
        w.lhs_imag = random_part();
        w.rhs_real = random_part();
        w.rhs_imag = random_part();
        if (w.action == ACT_DIV && $urandom_range(0, 19) == 0) begin
            w.rhs_real = '0;
            w.rhs_imag = '0;
        end
        return w;
    endfunction

    task automatic queue_word(t_action act, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d);
        t_in_word w;
        w.action = act;
        w.lhs_real = a; w.lhs_imag = b; w.rhs_real = c; w.rhs_imag = d;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_word <= pending_words.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_results.push_back(complex_result(i_word));
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word %h", o_word);
                    failed = 1'b1;
                end else begin
                    exp_word = expected_results.pop_front();
                    if (o_word.res_real !== exp_word.res_real) begin
                        $error("res_real exp %h got %h", exp_word.res_real, o_word.res_real);
                        failed = 1'b1;
                    end
                    if (o_word.res_imag !== exp_word.res_imag) begin
                        $error("res_imag exp %h got %h", exp_word.res_imag, o_word.res_imag);
                        failed = 1'b1;
                    end
                    if (o_word.overflow !== exp_word.overflow) begin
                        $error("overflow exp %b got %b", exp_word.overflow, o_word.overflow);
                        failed = 1'b1;
                    end
                    if (o_word.div_by_zero !== exp_word.div_by_zero) begin
                        $error("div_by_zero exp %b got %b", exp_word.div_by_zero,
                               o_word.div_by_zero);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 27;
        recv_idle_pct = 79;
        // directed words: extremes, every action, saturation, zero divisor
        queue_word(ACT_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
        queue_word(ACT_ADD, 32'h00010000, 32'h00020000, 32'hfffe0000, 32'h00008000);
        queue_word(ACT_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
        queue_word(ACT_SUB, 32'h00030000, 32'h0, 32'h00010000, 32'h00010000);
        queue_word(ACT_MUL, 32'h00010000, 32'h00010000, 32'h00010000, 32'hffff0000);
        queue_word(ACT_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_word(ACT_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        queue_word(ACT_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0);
        queue_word(ACT_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
        queue_word(ACT_DIV, 32'h00040000, 32'h00020000, 32'h00020000, 32'h0);
        queue_word(ACT_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
        queue_word(ACT_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_word(ACT_DIV, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h80000000);
        queue_word(ACT_DIV, 32'h00010000, 32'hffff0000, 32'h00000000, 32'h00000001);
        for (int i = 0; i < 600; i++) pending_words.push_back(random_word());
        drain();
        send_idle_pct = 79;
        recv_idle_pct = 27;
        for (int i = 0; i < 600; i++) pending_words.push_back(random_word());
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 640; i++) pending_words.push_back(random_word());
        @(posedge i_clk);
        hold_cycles <= 150;
        drain();
        repeat (50) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
